// File: hw/rtl/htt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the hierarchy transition tracker.
// Used by htt_front, htt_queue, htt_back and the top level; no dependencies.

package htt_pkg;

    // Default widths handed to the top-level parameters
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_POS_WIDTH   = 24;

    // Fixed field widths
    localparam int LIMIT_W   = 51;
    localparam int OUT_W     = 32;
    localparam int CLASS_W   = 3;
    localparam int TIDX_W    = 4;
    localparam int CFG_IDX_W = 3;

    // Counter banks
    localparam int NUM_TRANS = 12;
    localparam int NUM_DWELL = 4;
    localparam int DWELL_W   = $clog2(NUM_DWELL);

    // Queue between classifier and counter back end
    localparam int QUEUE_DEPTH = 4;

    // Hierarchy class codes
    localparam logic [CLASS_W-1:0] CLASS_NONE = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_12   = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_13   = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_14   = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_23   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_BODY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_BODY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_BODY1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_BODY0 = 3'd3;

    // One classified request as it travels through the queue
    typedef struct packed {
        logic               start;
        logic [CLASS_W-1:0] cls;
    } htt_item_t;

    // Queue side band: a valid flag with its item
    typedef struct packed {
        logic      valid;
        htt_item_t item;
    } htt_link_t;

endpackage

// File: hw/rtl/htt_front.sv
`timescale 1ns / 1ps
// Classifier front end: boundary registers and a three-stage pipeline that
// turns two positions into a hierarchy class. Depends on htt_pkg.

module htt_front #(
    parameter int POS_WIDTH = htt_pkg::DEF_POS_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           start_of_run,
    input  logic signed [POS_WIDTH-1:0]    pos0_x,
    input  logic signed [POS_WIDTH-1:0]    pos0_y,
    input  logic signed [POS_WIDTH-1:0]    pos1_x,
    input  logic signed [POS_WIDTH-1:0]    pos1_y,
    input  logic                           cfg_wr_en,
    input  logic [htt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [htt_pkg::LIMIT_W-1:0]    cfg_data,
    input  logic                           queue_full,
    output htt_pkg::htt_link_t             push
);
    import htt_pkg::*;

    localparam int EXT_W = POS_WIDTH + 1;
    localparam int SQ_W  = 2 * EXT_W;
    localparam int R_W   = SQ_W + 1;
    localparam int CMP_W = (R_W > LIMIT_W) ? R_W : LIMIT_W;

    logic [LIMIT_W-1:0] far_b0_reg;
    logic [LIMIT_W-1:0] near_b1_reg;
    logic [LIMIT_W-1:0] far_b1_reg;
    logic [LIMIT_W-1:0] near_b0_reg;

    logic advance;

    // stage 1: extended coordinates, differences and sums
    logic                    s1_valid_reg;
    logic                    s1_start_reg;
    logic signed [EXT_W-1:0] s1_x0_reg, s1_y0_reg, s1_x1_reg, s1_y1_reg;
    logic signed [EXT_W-1:0] s1_dx_reg, s1_dy_reg, s1_sx_reg, s1_sy_reg;
    logic signed [EXT_W-1:0] x0_ext, y0_ext, x1_ext, y1_ext;

    // stage 2: squares
    logic                    s2_valid_reg;
    logic                    s2_start_reg;
    logic [SQ_W-1:0]         s2_x0_reg, s2_y0_reg, s2_x1_reg, s2_y1_reg;
    logic [SQ_W-1:0]         s2_dx_reg, s2_dy_reg, s2_sx_reg, s2_sy_reg;
    logic signed [SQ_W-1:0]  p_x0, p_y0, p_x1, p_y1, p_dx, p_dy, p_sx, p_sy;

    // stage 3: squared distances
    logic                    s3_valid_reg;
    logic                    s3_start_reg;
    logic [R_W-1:0]          s3_r1_reg, s3_r2_reg, s3_r12_reg, s3_r13_reg;

    // classification compare operands
    logic [CMP_W-1:0] r1, r2, r12, r13, b1, b2, b3, b4;
    logic             outer;
    logic [CLASS_W-1:0] cls;

    // Hold the whole pipe while its last stage cannot enter the queue
    assign advance  = !(s3_valid_reg && queue_full);
    assign in_stall = !advance;

    // Boundary registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_b0_reg  <= '0;
            near_b1_reg <= '0;
            far_b1_reg  <= '0;
            near_b0_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FAR_BODY0:  far_b0_reg  <= cfg_data;
                CFG_NEAR_BODY1: near_b1_reg <= cfg_data;
                CFG_FAR_BODY1:  far_b1_reg  <= cfg_data;
                CFG_NEAR_BODY0: near_b0_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sign-extend positions by one bit so sums and differences cannot wrap
    assign x0_ext = {pos0_x[POS_WIDTH-1], pos0_x};
    assign y0_ext = {pos0_y[POS_WIDTH-1], pos0_y};
    assign x1_ext = {pos1_x[POS_WIDTH-1], pos1_x};
    assign y1_ext = {pos1_y[POS_WIDTH-1], pos1_y};

    // Valid bits of the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_start_reg <= start_of_run;
            s1_x0_reg    <= x0_ext;
            s1_y0_reg    <= y0_ext;
            s1_x1_reg    <= x1_ext;
            s1_y1_reg    <= y1_ext;
            s1_dx_reg    <= x0_ext - x1_ext;
            s1_dy_reg    <= y0_ext - y1_ext;
            s1_sx_reg    <= x0_ext + x1_ext;
            s1_sy_reg    <= y0_ext + y1_ext;
        end
    end

    // Stage 2: one multiplier per term
    assign p_x0 = s1_x0_reg * s1_x0_reg;
    assign p_y0 = s1_y0_reg * s1_y0_reg;
    assign p_x1 = s1_x1_reg * s1_x1_reg;
    assign p_y1 = s1_y1_reg * s1_y1_reg;
    assign p_dx = s1_dx_reg * s1_dx_reg;
    assign p_dy = s1_dy_reg * s1_dy_reg;
    assign p_sx = s1_sx_reg * s1_sx_reg;
    assign p_sy = s1_sy_reg * s1_sy_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_start_reg <= s1_start_reg;
            s2_x0_reg    <= $unsigned(p_x0);
            s2_y0_reg    <= $unsigned(p_y0);
            s2_x1_reg    <= $unsigned(p_x1);
            s2_y1_reg    <= $unsigned(p_y1);
            s2_dx_reg    <= $unsigned(p_dx);
            s2_dy_reg    <= $unsigned(p_dy);
            s2_sx_reg    <= $unsigned(p_sx);
            s2_sy_reg    <= $unsigned(p_sy);
        end
    end

    // Stage 3: add the squares
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_start_reg <= s2_start_reg;
            s3_r1_reg    <= R_W'(s2_x0_reg) + R_W'(s2_y0_reg);
            s3_r2_reg    <= R_W'(s2_x1_reg) + R_W'(s2_y1_reg);
            s3_r12_reg   <= R_W'(s2_dx_reg) + R_W'(s2_dy_reg);
            s3_r13_reg   <= R_W'(s2_sx_reg) + R_W'(s2_sy_reg);
        end
    end

    // Compare against the boundaries and pick the class
    assign r1  = CMP_W'(s3_r1_reg);
    assign r2  = CMP_W'(s3_r2_reg);
    assign r12 = CMP_W'(s3_r12_reg);
    assign r13 = CMP_W'(s3_r13_reg);
    assign b1  = CMP_W'(far_b0_reg);
    assign b2  = CMP_W'(near_b1_reg);
    assign b3  = CMP_W'(far_b1_reg);
    assign b4  = CMP_W'(near_b0_reg);

    assign outer = ((r1 > b1) && (r2 > b2)) || ((r1 > b4) && (r2 > b3));

    always_comb
    begin
        if ((r2 < b2) && (r1 > b1))
            cls = CLASS_23;
        else if ((r1 < b4) && (r2 > b3))
            cls = CLASS_14;
        else if (outer)
            cls = (r12 < r13) ? CLASS_12 : CLASS_13;
        else
            cls = CLASS_NONE;
    end

    assign push.valid      = s3_valid_reg;
    assign push.item.start = s3_start_reg;
    assign push.item.cls   = cls;

endmodule

// File: hw/rtl/htt_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified requests between front end and back end.
// Depends on htt_pkg.

module htt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  htt_pkg::htt_link_t push,
    output logic               full,
    output htt_pkg::htt_link_t head,
    input  logic               pop_ready
);
    import htt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    htt_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             empty;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = !empty && pop_ready;

    // Write storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.item;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign head.valid = !empty;
    assign head.item  = mem_reg[rd_ptr_reg];

    // Fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // A lone pop drops the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not drop on pop");

    // A full queue has its write pointer wrapped round to the read pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with full count");

endmodule

// File: hw/rtl/htt_back.sv
`timescale 1ns / 1ps
// Counter back end: last known class, transition and dwell counters, and the
// output register. Depends on htt_pkg.

module htt_back #(
    parameter int COUNT_WIDTH = htt_pkg::DEF_COUNT_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  htt_pkg::htt_link_t          head,
    output logic                        pop_ready,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [htt_pkg::CLASS_W-1:0] class_now,
    output logic                        changed,
    output logic [htt_pkg::TIDX_W-1:0]  transition_index,
    output logic [htt_pkg::OUT_W-1:0]   transition_total,
    output logic [htt_pkg::OUT_W-1:0]   dwell_total
);
    import htt_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

    logic [COUNT_WIDTH-1:0] trans_cnt_reg [NUM_TRANS];
    logic [COUNT_WIDTH-1:0] dwell_cnt_reg [NUM_DWELL];
    logic [CLASS_W-1:0]     last_class_reg;

    logic                   out_valid_reg;
    logic [CLASS_W-1:0]     class_reg;
    logic                   changed_reg;
    logic [TIDX_W-1:0]      tidx_reg;
    logic [OUT_W-1:0]       ttot_reg;
    logic [OUT_W-1:0]       dtot_reg;

    logic                   take;
    logic                   start;
    logic [CLASS_W-1:0]     cur;
    logic                   known;
    logic                   is_change;
    logic [DWELL_W-1:0]     didx;
    logic [DWELL_W-1:0]     src;
    logic [DWELL_W-1:0]     dst;
    logic [TIDX_W-1:0]      tidx;
    logic [COUNT_WIDTH-1:0] dwell_next;
    logic [COUNT_WIDTH-1:0] trans_next;
    logic [EXT_W-1:0]       dwell_ext;
    logic [EXT_W-1:0]       trans_ext;

    // Take a request whenever the output register is free or being drained
    assign pop_ready = !out_valid_reg || !out_stall;
    assign take      = head.valid && pop_ready;
    assign start     = head.item.start;
    assign cur       = head.item.cls;
    assign known     = (cur != CLASS_NONE);

    // Transition decode: source rank times three plus target position
    assign didx      = DWELL_W'(cur - 1'b1);
    assign src       = DWELL_W'(last_class_reg - 1'b1);
    assign dst       = didx;
    assign is_change = !start && known && (last_class_reg != CLASS_NONE)
                       && (last_class_reg <= CLASS_23) && (last_class_reg != cur);
    assign tidx      = TIDX_W'({src, 1'b0}) + TIDX_W'(src)
                       + ((dst > src) ? TIDX_W'(dst - 1'b1) : TIDX_W'(dst));

    // Saturating increments
    assign dwell_next = (dwell_cnt_reg[didx] == '1) ? dwell_cnt_reg[didx]
                                                    : dwell_cnt_reg[didx] + 1'b1;
    assign trans_next = (trans_cnt_reg[tidx] == '1) ? trans_cnt_reg[tidx]
                                                    : trans_cnt_reg[tidx] + 1'b1;
    assign dwell_ext  = EXT_W'(dwell_next);
    assign trans_ext  = EXT_W'(trans_next);

    // Counter state and last known class
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_class_reg <= CLASS_NONE;
            for (int i = 0; i < NUM_TRANS; i++)
                trans_cnt_reg[i] <= '0;
            for (int i = 0; i < NUM_DWELL; i++)
                dwell_cnt_reg[i] <= '0;
        end
        else if (take)
        begin
            if (start)
            begin
                last_class_reg <= cur;
                for (int i = 0; i < NUM_TRANS; i++)
                    trans_cnt_reg[i] <= '0;
                for (int i = 0; i < NUM_DWELL; i++)
                    dwell_cnt_reg[i] <= '0;
            end
            else if (known)
            begin
                last_class_reg      <= cur;
                dwell_cnt_reg[didx] <= dwell_next;
                if (is_change)
                    trans_cnt_reg[tidx] <= trans_next;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop_ready)
            out_valid_reg <= head.valid;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            class_reg   <= cur;
            changed_reg <= is_change;
            tidx_reg    <= is_change ? tidx : '0;
            ttot_reg    <= is_change ? trans_ext[OUT_W-1:0] : '0;
            dtot_reg    <= (!start && known) ? dwell_ext[OUT_W-1:0] : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign class_now        = class_reg;
    assign changed          = changed_reg;
    assign transition_index = tidx_reg;
    assign transition_total = ttot_reg;
    assign dwell_total      = dtot_reg;

    // A counted transition always lands on a determined class
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && changed_reg) |-> (class_reg != CLASS_NONE))
        else $error("transition counted on undetermined class");

    // A counted transition reports a live counter and a dwell step
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && changed_reg) |-> (ttot_reg != '0 && dtot_reg != '0))
        else $error("counted transition with empty totals");

    // Undetermined results carry no counts
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && class_reg == CLASS_NONE) |->
            (!changed_reg && dtot_reg == '0 && ttot_reg == '0))
        else $error("undetermined class with counts");

    // Last known class never falls back to undetermined outside a start of run
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !start && $past(1'b1)) |=> (last_class_reg != CLASS_NONE
            || $past(last_class_reg) == CLASS_NONE))
        else $error("last known class lost");

endmodule

// File: hw/rtl/hierarchy_transition_tracker_unit.sv
`timescale 1ns / 1ps
// Top level of the hierarchy transition tracker.
// Depends on htt_pkg, htt_front, htt_queue and htt_back.

// The tracker takes one position request per clock while in_stall is low and
// returns one result per request, in order. A request passes three classifier
// stages (coordinate sums, squares, squared distances with the boundary
// compare at the queue input), a four-entry queue and the counter update into
// the output register. Throughput is one request per cycle while neither
// stall is raised, set by the classifier pipeline and the read-modify-write
// of the counter banks. in_stall rises only when the queue is full and the
// result side has been stalled. Boundary registers take effect on the next
// request and must be written while the block is idle.

module hierarchy_transition_tracker_unit #(
    parameter int COUNT_WIDTH = htt_pkg::DEF_COUNT_WIDTH,
    parameter int POS_WIDTH   = htt_pkg::DEF_POS_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          start_of_run,
    input  logic signed [POS_WIDTH-1:0]   pos0_x,
    input  logic signed [POS_WIDTH-1:0]   pos0_y,
    input  logic signed [POS_WIDTH-1:0]   pos1_x,
    input  logic signed [POS_WIDTH-1:0]   pos1_y,
    input  logic                          cfg_wr_en,
    input  logic [htt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [htt_pkg::LIMIT_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [htt_pkg::CLASS_W-1:0]   class_now,
    output logic                          changed,
    output logic [htt_pkg::TIDX_W-1:0]    transition_index,
    output logic [htt_pkg::OUT_W-1:0]     transition_total,
    output logic [htt_pkg::OUT_W-1:0]     dwell_total
);
    import htt_pkg::*;

    htt_link_t push;
    htt_link_t head;
    logic      queue_full;
    logic      pop_ready;

    htt_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_of_run (start_of_run),
        .pos0_x       (pos0_x),
        .pos0_y       (pos0_y),
        .pos1_x       (pos1_x),
        .pos1_y       (pos1_y),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .queue_full   (queue_full),
        .push         (push)
    );

    htt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (queue_full),
        .head      (head),
        .pop_ready (pop_ready)
    );

    htt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .pop_ready        (pop_ready),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .class_now        (class_now),
        .changed          (changed),
        .transition_index (transition_index),
        .transition_total (transition_total),
        .dwell_total      (dwell_total)
    );

endmodule
